// ===== sv/akf_pkg.sv =====
// Shared types, constants and arithmetic helpers for the angle Kalman filter.
// No dependencies; the sequencer, datapath, top level and testbench import this package.
`default_nettype none
package akf_pkg;

    localparam int COV_FRAC_BITS  = 24;
    localparam int DT_FRAC_BITS   = 16;
    localparam int DIV_PRE_SHIFT  = 32 - COV_FRAC_BITS;
    localparam int DIV_STEPS      = 32;
    localparam int NOISE_W        = 27;

    localparam logic [NOISE_W-1:0] RST_ANGLE_NOISE = 27'd16777;
    localparam logic [NOISE_W-1:0] RST_BIAS_NOISE  = 27'd50332;
    localparam logic [NOISE_W-1:0] RST_MEAS_NOISE  = 27'd503316;

    localparam logic [1:0] CFG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] CFG_BIAS_NOISE  = 2'd1;
    localparam logic [1:0] CFG_MEAS_NOISE  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_OP, S_MUL, S_WB, S_DSET, S_DIV, S_DFIN, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        ST_RATE, ST_TPRED, ST_PAA, ST_PBB,
        ST_K0Y, ST_K1Y, ST_K0P00, ST_K0P01, ST_K1P00, ST_K1P01
    } t_step;

    typedef struct packed {
        logic  load_in;
        logic  op_load;
        logic  do_mul;
        logic  wb;
        t_step step;
        logic  div_setup;
        logic  div_iter;
        logic  div_fin;
        logic  out_load;
    } t_cmd;

    function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
        if (v > 70'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -70'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] gain_fin(input logic zero, input logic ovf,
                                                    input logic neg, input logic [31:0] q);
        if (zero) begin
            return 32'sd0;
        end else if (neg) begin
            if (ovf || q > 32'h80000000) begin
                return 32'sh80000000;
            end
            return 32'(0 - q);
        end
        if (ovf || q[31]) begin
            return 32'sh7fffffff;
        end
        return q;
    endfunction

endpackage
`default_nettype wire

// ===== sv/akf_if.sv =====
// Channel interfaces of the angle Kalman filter: sample input, result output, config.
// No dependencies.
`default_nettype none
interface akf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] acc_angle;
    logic signed [31:0] gyro_rate;
    logic        [15:0] time_step;
    modport source(output valid, acc_angle, gyro_rate, time_step, input ready);
    modport sink(input valid, acc_angle, gyro_rate, time_step, output ready);
endinterface

interface akf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] filtered_angle;
    logic signed [31:0] bias_out;
    modport source(output valid, filtered_angle, bias_out, input ready);
    modport sink(input valid, filtered_angle, bias_out, output ready);
endinterface

interface akf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/akf_ctrl.sv =====
// Sequencer of the angle Kalman filter: steps the datapath through predict,
// divide and correct. Depends on akf_pkg.
`default_nettype none
module akf_ctrl import akf_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  wire  i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);
    t_state     r_state, n_state;
    t_step      r_step, n_step;
    logic [4:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_RATE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.step = r_step;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_step  = ST_RATE;
                    n_state = S_OP;
                end
            end
            S_OP: begin
                o_cmd.op_load = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.do_mul = 1'b1;
                n_state = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                if (r_step == ST_PBB) begin
                    n_state = S_DSET;
                end else if (r_step == ST_K1P01) begin
                    n_state = S_DONE;
                end else begin
                    n_step  = t_step'(r_step + 1'b1);
                    n_state = S_OP;
                end
            end
            S_DSET: begin
                o_cmd.div_setup = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_iter = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                o_cmd.div_fin = 1'b1;
                n_step  = ST_K0Y;
                n_state = S_OP;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

// ===== sv/akf_datapath.sv =====
// Datapath of the angle Kalman filter: state, noise registers, shared multiplier
// and restoring division of both gains side by side on one divisor. Depends on akf_pkg.
`default_nettype none
module akf_datapath import akf_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cmd               i_cmd,
    input  wire signed [31:0]  i_acc_angle,
    input  wire signed [31:0]  i_gyro_rate,
    input  wire        [15:0]  i_time_step,
    input  wire                i_cfg_we,
    input  wire        [1:0]   i_cfg_index,
    input  wire        [31:0]  i_cfg_data,
    output logic signed [31:0] o_filtered_angle,
    output logic signed [31:0] o_bias_out
);
    logic signed [31:0] r_acc, r_gyro;
    logic        [15:0] r_dt;
    logic signed [31:0] r_angle, r_bias, r_paa, r_pab, r_pba, r_pbb;
    logic [NOISE_W-1:0] r_qa, r_qb, r_r;
    logic signed [35:0] r_a, r_inner;
    logic signed [32:0] r_b;
    logic signed [68:0] r_prod;
    logic signed [31:0] r_k0, r_k1, r_y, r_p00, r_p01;
    logic signed [31:0] r_out_angle, r_out_bias;
    logic        [33:0] r_smag, r_rem0, r_rem1;
    logic        [31:0] r_sq0, r_sq1;
    logic               r_szero, r_neg0, r_neg1, r_ovf0, r_ovf1;

    logic signed [68:0] rnd16, rndc;
    logic signed [35:0] n_a;
    logic signed [32:0] n_b;
    logic signed [33:0] s_sum;
    logic        [33:0] s_mag;
    logic        [32:0] n0_mag, n1_mag;
    logic        [63:0] d0, d1;
    logic        [34:0] rem2_0, rem2_1;
    logic               ge0, ge1;

    assign rnd16 = (r_prod + 69'sd32768) >>> DT_FRAC_BITS;
    assign rndc  = (r_prod + (69'sd1 <<< (COV_FRAC_BITS - 1))) >>> COV_FRAC_BITS;

    assign s_sum  = 34'(r_paa) + 34'({1'b0, r_r});
    assign s_mag  = s_sum[33] ? 34'(0 - s_sum) : s_sum;
    assign n0_mag = r_paa[31] ? 33'(0 - 33'(r_paa)) : 33'(r_paa);
    assign n1_mag = r_pba[31] ? 33'(0 - 33'(r_pba)) : 33'(r_pba);
    assign d0     = 64'(n0_mag) << COV_FRAC_BITS;
    assign d1     = 64'(n1_mag) << COV_FRAC_BITS;

    assign rem2_0 = {r_rem0, r_sq0[31]};
    assign rem2_1 = {r_rem1, r_sq1[31]};
    assign ge0    = rem2_0 >= 35'(r_smag);
    assign ge1    = rem2_1 >= 35'(r_smag);

    always_comb begin
        n_a = 36'(r_pbb);
        n_b = 33'({1'b0, r_dt});
        case (i_cmd.step)
            ST_RATE:  n_a = 36'(sat32(70'(r_gyro) - 70'(r_bias)));
            ST_TPRED: n_a = 36'(r_pbb);
            ST_PAA:   n_a = r_inner;
            ST_PBB:   n_a = 36'({1'b0, r_qb});
            ST_K0Y:   begin n_a = 36'(r_y);   n_b = 33'(r_k0); end
            ST_K1Y:   begin n_a = 36'(r_y);   n_b = 33'(r_k1); end
            ST_K0P00: begin n_a = 36'(r_p00); n_b = 33'(r_k0); end
            ST_K0P01: begin n_a = 36'(r_p01); n_b = 33'(r_k0); end
            ST_K1P00: begin n_a = 36'(r_p00); n_b = 33'(r_k1); end
            ST_K1P01: begin n_a = 36'(r_p01); n_b = 33'(r_k1); end
            default:  n_a = 36'(r_pbb);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa    <= RST_ANGLE_NOISE;
            r_qb    <= RST_BIAS_NOISE;
            r_r     <= RST_MEAS_NOISE;
            r_angle <= '0;
            r_bias  <= '0;
            r_paa   <= '0;
            r_pab   <= '0;
            r_pba   <= '0;
            r_pbb   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ANGLE_NOISE: r_qa <= i_cfg_data[NOISE_W-1:0];
                    CFG_BIAS_NOISE:  r_qb <= i_cfg_data[NOISE_W-1:0];
                    CFG_MEAS_NOISE:  r_r  <= i_cfg_data[NOISE_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.wb) begin
                case (i_cmd.step)
                    ST_RATE:  r_angle <= sat32(70'(r_angle) + 70'(rnd16));
                    ST_TPRED: begin
                        r_pab <= sat32(70'(r_pab) - 70'(rnd16));
                        r_pba <= sat32(70'(r_pba) - 70'(rnd16));
                    end
                    ST_PAA:   r_paa   <= sat32(70'(r_paa) + 70'(rnd16));
                    ST_PBB:   r_pbb   <= sat32(70'(r_pbb) + 70'(rnd16));
                    ST_K0Y:   r_angle <= sat32(70'(r_angle) + 70'(rndc));
                    ST_K1Y:   r_bias  <= sat32(70'(r_bias) + 70'(rndc));
                    ST_K0P00: r_paa   <= sat32(70'(r_p00) - 70'(rndc));
                    ST_K0P01: r_pab   <= sat32(70'(r_p01) - 70'(rndc));
                    ST_K1P00: r_pba   <= sat32(70'(r_pba) - 70'(rndc));
                    ST_K1P01: r_pbb   <= sat32(70'(r_pbb) - 70'(rndc));
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_acc  <= i_acc_angle;
            r_gyro <= i_gyro_rate;
            r_dt   <= i_time_step;
        end
        if (i_cmd.op_load) begin
            r_a <= n_a;
            r_b <= n_b;
        end
        if (i_cmd.do_mul) begin
            r_prod <= r_a * r_b;
        end
        if (i_cmd.wb && i_cmd.step == ST_TPRED) begin
            r_inner <= 36'(rnd16) - 36'(r_pba) - 36'(r_pab) + 36'({1'b0, r_qa});
        end
        if (i_cmd.div_setup) begin
            r_smag  <= s_mag;
            r_szero <= (s_sum == 34'sd0);
            r_neg0  <= r_paa[31] ^ s_sum[33];
            r_neg1  <= r_pba[31] ^ s_sum[33];
            r_ovf0  <= 50'(n0_mag) >= (50'(s_mag) << DIV_PRE_SHIFT);
            r_ovf1  <= 50'(n1_mag) >= (50'(s_mag) << DIV_PRE_SHIFT);
            r_rem0  <= 34'(d0 >> 32);
            r_rem1  <= 34'(d1 >> 32);
            r_sq0   <= d0[31:0];
            r_sq1   <= d1[31:0];
        end
        if (i_cmd.div_iter) begin
            r_rem0 <= ge0 ? 34'(rem2_0 - 35'(r_smag)) : rem2_0[33:0];
            r_rem1 <= ge1 ? 34'(rem2_1 - 35'(r_smag)) : rem2_1[33:0];
            r_sq0  <= {r_sq0[30:0], ge0};
            r_sq1  <= {r_sq1[30:0], ge1};
        end
        if (i_cmd.div_fin) begin
            r_k0  <= gain_fin(r_szero, r_ovf0, r_neg0, r_sq0);
            r_k1  <= gain_fin(r_szero, r_ovf1, r_neg1, r_sq1);
            r_y   <= sat32(70'(r_acc) - 70'(r_angle));
            r_p00 <= r_paa;
            r_p01 <= r_pab;
        end
        if (i_cmd.out_load) begin
            r_out_angle <= r_angle;
            r_out_bias  <= r_bias;
        end
    end

    assign o_filtered_angle = r_out_angle;
    assign o_bias_out       = r_out_bias;
endmodule
`default_nettype wire

// ===== sv/angle_kalman_filter_unit.sv =====
// Angle Kalman filter top level: controller plus datapath on request channels.
// One request at a time: a new request is taken only once the last result is loaded.
// Each request takes ten multiplies on the shared multiplier and a 32-step gain divider.
// A waiting result holds the next result in the sequencer, and with it the input,
// until the output register drains.
// Reset (i_rst_n low, synchronous): estimates and covariance cleared, noise to defaults.
`default_nettype none
module angle_kalman_filter_unit import akf_pkg::*; (
    input wire           i_clk,
    input wire           i_rst_n,
    akf_in_if.sink       i_in,
    akf_out_if.source    o_out,
    akf_cfg_if.sink      i_cfg
);
    t_cmd cmd;
    logic in_ready;
    logic out_valid;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    akf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    akf_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_acc_angle      (i_in.acc_angle),
        .i_gyro_rate      (i_in.gyro_rate),
        .i_time_step      (i_in.time_step),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .o_filtered_angle (o_out.filtered_angle),
        .o_bias_out       (o_out.bias_out)
    );
endmodule
`default_nettype wire

// ===== tb/tb_if.sv =====
// Testbench-side copies are not needed; the channel interfaces come from sv/akf_if.sv.
// This file holds the shared testbench types and has no dependencies.
`timescale 1ns / 100ps
package tb_akf_pkg;
    typedef struct packed {
        logic signed [31:0] acc_angle;
        logic signed [31:0] gyro_rate;
        logic        [15:0] time_step;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] filtered_angle;
        logic signed [31:0] bias_out;
    } t_estimate;
endpackage

// ===== tb/testbench.sv =====
// Testbench for angle_kalman_filter_unit: random and directed samples with random gaps,
// output stalls and noise register writes, checked against an in-bench filter predictor.
// Depends on akf_pkg, the channel interfaces in sv/akf_if.sv and tb_akf_pkg.
`timescale 1ns / 100ps
module testbench;
    import akf_pkg::*;
    import tb_akf_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    akf_in_if  in_ch();
    akf_out_if out_ch();
    akf_cfg_if cfg_ch();

    angle_kalman_filter_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch), .i_cfg(cfg_ch)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    t_sample   sample_q[$];
    t_estimate estimate_q[$];
    int        mismatches = 0;
    bit        hold_input = 1'b0;

    logic signed [31:0] m_angle, m_bias, m_paa, m_pab, m_pba, m_pbb;
    logic [26:0]        m_qa, m_qb, m_r;

    function automatic logic signed [31:0] clip32(input logic signed [95:0] v);
        if (v > 96'sd2147483647) return 32'sh7fffffff;
        if (v < -96'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [95:0] round_shr(input logic signed [95:0] v, input int s);
        return (v + (96'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] gain_of(input logic signed [95:0] num,
                                                  input logic signed [95:0] den);
        if (den == 0) return 32'sd0;
        return clip32((num <<< COV_FRAC_BITS) / den);
    endfunction

    task automatic filter_reset();
        m_angle = 0; m_bias = 0; m_paa = 0; m_pab = 0; m_pba = 0; m_pbb = 0;
        m_qa = RST_ANGLE_NOISE; m_qb = RST_BIAS_NOISE; m_r = RST_MEAS_NOISE;
    endtask

    task automatic filter_update(input t_sample s);
        logic signed [95:0] dt, rate, t, inner, den, y, p00, p01;
        logic signed [31:0] k0, k1;
        t_estimate e;
        dt = {80'd0, s.time_step};
        rate = clip32(96'(s.gyro_rate) - 96'(m_bias));
        m_angle = clip32(96'(m_angle) + round_shr(dt * rate, DT_FRAC_BITS));
        t = round_shr(dt * 96'(m_pbb), DT_FRAC_BITS);
        inner = t - 96'(m_pba) - 96'(m_pab) + {69'd0, m_qa};
        m_paa = clip32(96'(m_paa) + round_shr(dt * inner, DT_FRAC_BITS));
        m_pab = clip32(96'(m_pab) - t);
        m_pba = clip32(96'(m_pba) - t);
        m_pbb = clip32(96'(m_pbb) + round_shr({69'd0, m_qb} * dt, DT_FRAC_BITS));
        den = 96'(m_paa) + {69'd0, m_r};
        k0 = gain_of(96'(m_paa), den);
        k1 = gain_of(96'(m_pba), den);
        y = clip32(96'(s.acc_angle) - 96'(m_angle));
        m_angle = clip32(96'(m_angle) + round_shr(96'(k0) * y, COV_FRAC_BITS));
        m_bias = clip32(96'(m_bias) + round_shr(96'(k1) * y, COV_FRAC_BITS));
        p00 = 96'(m_paa);
        p01 = 96'(m_pab);
        m_paa = clip32(p00 - round_shr(96'(k0) * p00, COV_FRAC_BITS));
        m_pab = clip32(p01 - round_shr(96'(k0) * p01, COV_FRAC_BITS));
        m_pba = clip32(96'(m_pba) - round_shr(96'(k1) * p00, COV_FRAC_BITS));
        m_pbb = clip32(96'(m_pbb) - round_shr(96'(k1) * p01, COV_FRAC_BITS));
        e.filtered_angle = m_angle;
        e.bias_out = m_bias;
        estimate_q.push_back(e);
    endtask

    // driver: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.acc_angle <= '0;
            in_ch.gyro_rate <= '0;
            in_ch.time_step <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                filter_update(sample_q.pop_front());
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold current request
            end else if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (sample_q.size() > 0 && !hold_input) begin
                in_ch.valid <= 1'b1;
                in_ch.acc_angle <= sample_q[0].acc_angle;
                in_ch.gyro_rate <= sample_q[0].gyro_rate;
                in_ch.time_step <= sample_q[0].time_step;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 8);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 120);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor with stall pattern
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (estimate_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h %h",
                        out_ch.filtered_angle, out_ch.bias_out);
                end else begin
                    t_estimate e;
                    e = estimate_q.pop_front();
                    if (e.filtered_angle !== out_ch.filtered_angle ||
                        e.bias_out !== out_ch.bias_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: angle exp %h got %h, bias exp %h got %h",
                                e.filtered_angle, out_ch.filtered_angle,
                                e.bias_out, out_ch.bias_out);
                    end
                end
            end
            stall_phase++;
            if (stall_phase % 512 < 128) out_ch.ready <= 1'b1;
            else out_ch.ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 37 > 6);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_ANGLE_NOISE) m_qa = val[26:0];
        else if (idx == CFG_BIAS_NOISE) m_qb = val[26:0];
        else if (idx == CFG_MEAS_NOISE) m_r = val[26:0];
    endtask

    task automatic wait_idle();
        while (sample_q.size() > 0 || in_ch.valid || estimate_q.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample(input int mode);
        t_sample s;
        s.acc_angle = $urandom;
        s.gyro_rate = $urandom;
        s.time_step = 16'($urandom);
        if (mode != 0) begin
            s.acc_angle = $signed($urandom_range(0, 2 * 90 * 65536)) - 90 * 65536;
            s.gyro_rate = $signed($urandom_range(0, 2 * 500 * 65536)) - 500 * 65536;
            s.time_step = 16'($urandom_range(1, 1000));
        end
        return s;
    endfunction

    function automatic t_sample mk(input logic [31:0] a, input logic [31:0] g,
                                   input logic [15:0] d);
        t_sample s;
        s.acc_angle = a; s.gyro_rate = g; s.time_step = d;
        return s;
    endfunction

    initial begin
        logic [26:0] cfg_sets[4][3];
        in_ch.valid = 1'b0; in_ch.acc_angle = '0; in_ch.gyro_rate = '0; in_ch.time_step = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
        filter_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sample_q.push_back(mk(32'h7fffffff, 32'h80000000, 16'hffff));
        sample_q.push_back(mk(32'h80000000, 32'h7fffffff, 16'hffff));
        sample_q.push_back(mk(32'd0, 32'd0, 16'd0));
        sample_q.push_back(mk(32'h00100000, 32'h00050000, 16'd0));
        sample_q.push_back(mk(32'h7fffffff, 32'h7fffffff, 16'd1));
        sample_q.push_back(mk(32'h80000000, 32'h80000000, 16'd1));
        sample_q.push_back(mk(32'h55555555, 32'haaaaaaaa, 16'h5555));
        sample_q.push_back(mk(32'haaaaaaaa, 32'h55555555, 16'haaaa));
        wait_idle();

        // zero measurement noise, extreme process noise
        write_reg(CFG_MEAS_NOISE, 32'd0);
        write_reg(CFG_ANGLE_NOISE, 32'hffffffff);
        write_reg(CFG_BIAS_NOISE, 32'h07ffffff);
        write_reg(2'd3, 32'h12345678);
        sample_q.push_back(mk(32'h00010000, 32'h00020000, 16'd0));
        sample_q.push_back(mk(32'h00010000, 32'h00020000, 16'hffff));
        sample_q.push_back(mk(32'h80000000, 32'h7fffffff, 16'd655));
        sample_q.push_back(mk(32'h7fffffff, 32'h80000000, 16'd655));
        wait_idle();

        cfg_sets = '{'{27'd16777, 27'd50332, 27'd503316},
                     '{27'd0, 27'd0, 27'd1},
                     '{27'h7ffffff, 27'h7ffffff, 27'h7ffffff},
                     '{27'd1000, 27'd3000, 27'd30000}};
        for (int ph = 0; ph < 8; ph++) begin
            int n;
            write_reg(CFG_ANGLE_NOISE, (ph < 4) ? cfg_sets[ph][0] : $urandom);
            write_reg(CFG_BIAS_NOISE, (ph < 4) ? cfg_sets[ph][1] : $urandom);
            write_reg(CFG_MEAS_NOISE, (ph < 4) ? cfg_sets[ph][2] : $urandom);
            n = 128;
            for (int k = 0; k < n; k++)
                sample_q.push_back(rand_sample(($urandom_range(0, 4) != 0) ? 1 : 0));
            if (ph == 3) begin
                while (sample_q.size() > 64) @(posedge i_clk);
                hold_input = 1'b1;
                while (in_ch.valid || estimate_q.size() > 0) @(posedge i_clk);
                hold_input = 1'b0;
            end
            wait_idle();
        end
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule
